[rtl/lspg_pkg.sv]
// types and constants shared by the status led pattern generator
// no dependencies

package lspg_pkg;

	typedef struct packed {
		logic       tick;
		logic [2:0] mode;
	} item_t;

	typedef struct packed {
		logic led_lit;
		logic reset_request;
	} result_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int LEN_W       = 16;
	localparam int BLINK_W     = 4;

	// display modes
	localparam logic [2:0] MODE_HEARTBEAT = 3'd0;
	localparam logic [2:0] MODE_SLOW      = 3'd1;
	localparam logic [2:0] MODE_FAST      = 3'd2;
	localparam logic [2:0] MODE_SUCCESS   = 3'd3;
	localparam logic [2:0] MODE_ERROR     = 3'd4;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PULSE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_PAUSE = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOW_HALF       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ERROR_PULSE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ERROR_PAUSE     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SUCCESS_HOLD    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ERROR_BLINKS    = 3'd6;

	// register reset values
	localparam logic [LEN_W-1:0]   RST_SHORT_PULSE     = 16'd50;
	localparam logic [LEN_W-1:0]   RST_HEARTBEAT_PAUSE = 16'd850;
	localparam logic [LEN_W-1:0]   RST_SLOW_HALF       = 16'd500;
	localparam logic [LEN_W-1:0]   RST_ERROR_PULSE     = 16'd100;
	localparam logic [LEN_W-1:0]   RST_ERROR_PAUSE     = 16'd1000;
	localparam logic [LEN_W-1:0]   RST_SUCCESS_HOLD    = 16'd3000;
	localparam logic [BLINK_W-1:0] RST_ERROR_BLINKS    = 4'd3;

endpackage

[rtl/led_status_pattern_generator_core.sv]
// status led pattern generator: heartbeat, blink, success and error patterns
// depends on lspg_pkg
// flow: an accepted item is held in the input register and its result is then
// registered in the output register; throughput: one item per cycle unless
// result_stall holds a waiting result, when the input register holds one more item
// reset: pattern state clears, registers take their default lengths, both
// pipeline stages empty

module led_status_pattern_generator_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  lspg_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output lspg_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lspg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lspg_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int LW    = lspg_pkg::LEN_W;
	localparam int BW    = lspg_pkg::BLINK_W;
	localparam int CMP_W = (TIMER_WIDTH > LW) ? TIMER_WIDTH : LW;

	// configuration registers
	logic [LW-1:0] short_pulse_q;
	logic [LW-1:0] heartbeat_pause_q;
	logic [LW-1:0] slow_half_q;
	logic [LW-1:0] error_pulse_q;
	logic [LW-1:0] error_pause_q;
	logic [LW-1:0] success_hold_q;
	logic [BW-1:0] error_blinks_q;

	// pattern state
	logic [1:0]             phase_q;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic [BW-1:0]          blink_count_q;
	logic                   success_started_q;
	logic [TIMER_WIDTH-1:0] success_elapsed_q;

	// pipeline
	logic              valid_s1;
	lspg_pkg::item_t   item_s1;
	logic              out_valid_q;
	lspg_pkg::result_t result_q;

	logic advance;

	assign cfg_ready    = 1'b1;
	assign advance      = valid_s1 && (!out_valid_q || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign result_valid = out_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_pulse_q     <= lspg_pkg::RST_SHORT_PULSE;
			heartbeat_pause_q <= lspg_pkg::RST_HEARTBEAT_PAUSE;
			slow_half_q       <= lspg_pkg::RST_SLOW_HALF;
			error_pulse_q     <= lspg_pkg::RST_ERROR_PULSE;
			error_pause_q     <= lspg_pkg::RST_ERROR_PAUSE;
			success_hold_q    <= lspg_pkg::RST_SUCCESS_HOLD;
			error_blinks_q    <= lspg_pkg::RST_ERROR_BLINKS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lspg_pkg::REG_SHORT_PULSE:     short_pulse_q     <= cfg_data;
				lspg_pkg::REG_HEARTBEAT_PAUSE: heartbeat_pause_q <= cfg_data;
				lspg_pkg::REG_SLOW_HALF:       slow_half_q       <= cfg_data;
				lspg_pkg::REG_ERROR_PULSE:     error_pulse_q     <= cfg_data;
				lspg_pkg::REG_ERROR_PAUSE:     error_pause_q     <= cfg_data;
				lspg_pkg::REG_SUCCESS_HOLD:    success_hold_q    <= cfg_data;
				lspg_pkg::REG_ERROR_BLINKS:    error_blinks_q    <= cfg_data[BW-1:0];
				default: ;
			endcase
		end
	end

	// next-state logic for the item held in the input register
	logic [TIMER_WIDTH-1:0] el;
	logic [TIMER_WIDTH-1:0] se;
	logic [LW-1:0]          seg_len;
	logic                   seg_en;
	logic                   seg_done;
	logic                   lit;
	logic                   req;
	logic [1:0]             phase_d;
	logic [TIMER_WIDTH-1:0] elapsed_d;
	logic [BW-1:0]          blink_d;
	logic                   started_d;
	logic [TIMER_WIDTH-1:0] success_d;

	always_comb begin
		el = elapsed_q;
		se = success_elapsed_q;
		if (item_s1.tick) begin
			if (elapsed_q != {TIMER_WIDTH{1'b1}})
				el = elapsed_q + 1'b1;
			if (success_started_q && (success_elapsed_q != {TIMER_WIDTH{1'b1}}))
				se = success_elapsed_q + 1'b1;
		end

		seg_len = short_pulse_q;
		seg_en  = 1'b0;
		lit     = 1'b0;
		case (item_s1.mode)
			lspg_pkg::MODE_HEARTBEAT: begin
				seg_en  = 1'b1;
				lit     = (phase_q inside {2'd0, 2'd2});
				seg_len = (phase_q == 2'd3) ? heartbeat_pause_q : short_pulse_q;
			end
			lspg_pkg::MODE_SLOW, lspg_pkg::MODE_FAST: begin
				seg_en  = 1'b1;
				lit     = (phase_q == 2'd0);
				seg_len = (item_s1.mode == lspg_pkg::MODE_SLOW) ? slow_half_q : short_pulse_q;
			end
			lspg_pkg::MODE_SUCCESS: begin
				lit = 1'b1;
			end
			lspg_pkg::MODE_ERROR: begin
				seg_en = 1'b1;
				if (blink_count_q < error_blinks_q) begin
					lit     = (phase_q == 2'd0);
					seg_len = error_pulse_q;
				end else begin
					seg_len = error_pause_q;
				end
			end
			default: ;
		endcase

		// zero-extend both sides so a length above the timer range is never reached
		seg_done = seg_en &&
			(CMP_W'(el) >= CMP_W'(seg_len));
		elapsed_d = seg_done ? '0 : el;

		phase_d   = phase_q;
		blink_d   = blink_count_q;
		started_d = success_started_q;
		success_d = se;
		req       = 1'b0;
		case (item_s1.mode)
			lspg_pkg::MODE_HEARTBEAT: begin
				if (seg_done)
					phase_d = phase_q + 2'd1;
			end
			lspg_pkg::MODE_SLOW, lspg_pkg::MODE_FAST: begin
				if (seg_done)
					phase_d = (phase_q == 2'd0) ? 2'd1 : 2'd0;
			end
			lspg_pkg::MODE_SUCCESS: begin
				if (!success_started_q) begin
					started_d = 1'b1;
					success_d = '0;
				end else begin
					req = (CMP_W'(se) >= CMP_W'(success_hold_q));
				end
			end
			lspg_pkg::MODE_ERROR: begin
				if (seg_done) begin
					if (blink_count_q < error_blinks_q) begin
						if (phase_q == 2'd0) begin
							phase_d = 2'd1;
							blink_d = blink_count_q + 1'b1;
						end else begin
							phase_d = 2'd0;
						end
					end else begin
						// pause over, phase kept
						blink_d = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			out_valid_q       <= 1'b0;
			phase_q           <= '0;
			elapsed_q         <= '0;
			blink_count_q     <= '0;
			success_started_q <= 1'b0;
			success_elapsed_q <= '0;
		end else begin
			if (item_valid && !item_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;

			if (advance)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;

			if (advance) begin
				phase_q           <= phase_d;
				elapsed_q         <= elapsed_d;
				blink_count_q     <= blink_d;
				success_started_q <= started_d;
				success_elapsed_q <= success_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
		if (advance) begin
			result_q.led_lit       <= lit;
			result_q.reset_request <= req;
		end
	end

endmodule
